### rtl/grg_pkg.sv
package grg_pkg;

    localparam int GLYPH_COUNT = 47;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;

    // Glyph table slots: letters, then digits, then punctuation, then blank.
    localparam logic [5:0] IDX_DIGIT_BASE = 6'd26;
    localparam logic [5:0] IDX_PERIOD     = 6'd36;
    localparam logic [5:0] IDX_COLON      = 6'd37;
    localparam logic [5:0] IDX_SLASH      = 6'd38;
    localparam logic [5:0] IDX_MINUS      = 6'd39;
    localparam logic [5:0] IDX_PLUS       = 6'd40;
    localparam logic [5:0] IDX_GREATER    = 6'd41;
    localparam logic [5:0] IDX_LESS       = 6'd42;
    localparam logic [5:0] IDX_LBRACKET   = 6'd43;
    localparam logic [5:0] IDX_RBRACKET   = 6'd44;
    localparam logic [5:0] IDX_BANG       = 6'd45;
    localparam logic [5:0] IDX_BLANK      = 6'd46;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // Rows from top to bottom; bit 4 is the leftmost column.
    localparam logic [GLYPH_COLS-1:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
        '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
        '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
        '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31},
        '{5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
        '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
        '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
        '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
        '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
        '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
        '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
        '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
        '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
        '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
        '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
        '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
        '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14},
        '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4},
        '{5'd0,  5'd0,  5'd4,  5'd0,  5'd0,  5'd4,  5'd0},
        '{5'd1,  5'd1,  5'd2,  5'd4,  5'd4,  5'd8,  5'd16},
        '{5'd0,  5'd0,  5'd0,  5'd14, 5'd0,  5'd0,  5'd0},
        '{5'd0,  5'd0,  5'd4,  5'd14, 5'd4,  5'd0,  5'd0},
        '{5'd0,  5'd8,  5'd4,  5'd2,  5'd4,  5'd8,  5'd0},
        '{5'd0,  5'd2,  5'd4,  5'd8,  5'd4,  5'd2,  5'd0},
        '{5'd6,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd6},
        '{5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd12},
        '{5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4},
        '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0}
    };

    typedef struct packed {
        logic       rd_en;
        logic [5:0] glyph_idx;
        logic [2:0] row;
    } rom_req_t;

    // Maps a character byte to its glyph table slot, folding lowercase.
    function automatic logic [5:0] char_index(input logic [7:0] code);
        logic [7:0] c;
        logic [5:0] idx;
        c = code;
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            c = c - 8'd32;
        end
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            idx = 6'(c - 8'h41);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            idx = 6'(c - 8'h30) + IDX_DIGIT_BASE;
        end
        else
        begin
            case (c)
                8'h2e:   idx = IDX_PERIOD;
                8'h3a:   idx = IDX_COLON;
                8'h2f:   idx = IDX_SLASH;
                8'h2d:   idx = IDX_MINUS;
                8'h2b:   idx = IDX_PLUS;
                8'h3e:   idx = IDX_GREATER;
                8'h3c:   idx = IDX_LESS;
                8'h5b:   idx = IDX_LBRACKET;
                8'h5d:   idx = IDX_RBRACKET;
                8'h21:   idx = IDX_BANG;
                default: idx = IDX_BLANK;
            endcase
        end
        return idx;
    endfunction

endpackage

### rtl/grg_glyph_rom.sv
// Synchronous glyph ROM: one row of one glyph per read, with the data in the cycle after the read.
module grg_glyph_rom
(
    input  logic                              clk,
    input  grg_pkg::rom_req_t                 req,
    output logic [grg_pkg::GLYPH_COLS-1:0]    rd_data
);

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= grg_pkg::GLYPH_ROM[req.glyph_idx][req.row];
        end
    end

endmodule

### rtl/glyph_run_rectangle_generator_core.sv
// Flow: a character beat is accepted only when idle, so the next character waits until the
// last row of this one closes. For each of the seven rows the glyph ROM is read, the row is
// loaded, each of its runs is emitted as a rectangle once the output register is free, and
// the row closes. A character emits N rectangles (at most 17); a newline emits nothing.
// Reset: rst_n is asynchronous and active low; pen, origin and color clear to zero and
// the held scale to one. The glyph ROM needs no initialization.
module glyph_run_rectangle_generator_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], start_x[23:8], start_y[39:24], pixel_scale[43:40], ink[75:44],
    // zero pad[79:76]
    input  logic [79:0] s_axis_tdata,
    // first[0]
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rect_x[15:0], rect_y[31:16], rect_w[38:32], rect_h[42:39], rect_color[74:43],
    // zero pad[79:75]
    output logic [79:0] m_axis_tdata,
    // last_of_char
    output logic        m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_RUN
    } state_t;

    // One horizontal run found in the remaining bits of a row.
    typedef struct packed {
        logic       found;
        logic [2:0] start;
        logic [2:0] len;
        logic [4:0] rest;
    } run_t;

    // Scans a row left to right (bit 4 first) and removes the first run of set pixels.
    function automatic run_t find_run(input logic [4:0] bits);
        run_t res;
        logic ended;
        res   = '0;
        ended = 1'b0;
        res.rest = bits;
        for (int col = 0; col < 5; col++)
        begin
            if (bits[4 - col] && !ended)
            begin
                if (!res.found)
                begin
                    res.start = 3'(col);
                end
                res.found = 1'b1;
                res.len   = res.len + 3'd1;
                res.rest[4 - col] = 1'b0;
            end
            else if (res.found)
            begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

    // Marks the rows of a glyph that hold at least one set pixel.
    function automatic logic [6:0] row_mask(input logic [5:0] idx);
        logic [6:0] m;
        for (int r = 0; r < 7; r++)
        begin
            m[r] = |grg_pkg::GLYPH_ROM[idx][r];
        end
        return m;
    endfunction

    state_t      state_reg;
    logic [2:0]  row_reg;
    logic [4:0]  rem_reg;
    logic [6:0]  mask_reg;
    logic [5:0]  idx_reg;
    logic [15:0] origin_x_reg;
    logic [15:0] pen_x_reg;
    logic [15:0] pen_y_reg;
    logic [3:0]  scale_reg;
    logic [31:0] color_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [6:0]  out_w_reg;
    logic [3:0]  out_h_reg;
    logic [31:0] out_color_reg;
    logic        out_last_reg;

    // Input beat fields.
    logic [7:0]  in_char;
    logic [15:0] in_start_x;
    logic [15:0] in_start_y;
    logic [3:0]  in_scale;
    logic [31:0] in_ink;
    logic        in_first;
    logic        in_accept;

    // String state after an optional load by the first flag.
    logic [15:0] eff_origin_x;
    logic [15:0] eff_pen_x;
    logic [15:0] eff_pen_y;
    logic [3:0]  eff_scale;
    logic [31:0] eff_color;
    logic [5:0]  in_idx;

    logic [4:0]         rom_data;
    grg_pkg::rom_req_t  rom_req;
    run_t               run;
    logic               out_free;
    logic               later_rows;
    logic [6:0]         x_off;
    logic [6:0]         y_off;
    logic [6:0]         w_val;
    logic [7:0]         newline_step;
    logic [6:0]         advance;

    assign in_char    = s_axis_tdata[7:0];
    assign in_start_x = s_axis_tdata[23:8];
    assign in_start_y = s_axis_tdata[39:24];
    assign in_scale   = s_axis_tdata[43:40];
    assign in_ink     = s_axis_tdata[75:44];
    assign in_first   = s_axis_tuser[0];

    // A new character is taken only between characters; the output register lets the
    // last rectangle of the previous one wait downstream meanwhile.
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign eff_origin_x = in_first ? in_start_x : origin_x_reg;
    assign eff_pen_x    = in_first ? in_start_x : pen_x_reg;
    assign eff_pen_y    = in_first ? in_start_y : pen_y_reg;
    assign eff_scale    = in_first ? in_scale   : scale_reg;
    assign eff_color    = in_first ? in_ink     : color_reg;
    assign in_idx       = grg_pkg::char_index(in_char);

    assign newline_step = 8'd10 * 8'(eff_scale);
    assign advance      = 7'd6 * 7'(scale_reg);

    // Row 0 is read on the accept cycle; each following row when the current one closes.
    always_comb
    begin
        rom_req = '0;
        if (state_reg == S_IDLE)
        begin
            rom_req.rd_en     = in_accept && (in_char != grg_pkg::CHAR_NEWLINE);
            rom_req.glyph_idx = in_idx;
            rom_req.row       = 3'd0;
        end
        else
        begin
            rom_req.rd_en     = (state_reg == S_RUN) && (rem_reg == 5'd0) &&
                                (row_reg != 3'd6);
            rom_req.glyph_idx = idx_reg;
            rom_req.row       = row_reg + 3'd1;
        end
    end

    grg_glyph_rom u_rom
    (
        .clk     (clk),
        .req     (rom_req),
        .rd_data (rom_data)
    );

    assign run      = find_run(rem_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    // The output register fills when a run is emitted and empties when its beat is taken.
    assign out_valid_next = ((state_reg == S_RUN) && (rem_reg != 5'd0) && out_free) ||
                            (out_valid_reg && !m_axis_tready);

    // A run closes the character when nothing is left in its row or in any row below.
    assign later_rows = |(mask_reg >> (row_reg + 3'd1));

    assign x_off = 7'(run.start) * 7'(scale_reg);
    assign y_off = 7'(row_reg) * 7'(scale_reg);
    assign w_val = 7'(run.len) * 7'(scale_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= 3'd0;
            rem_reg       <= 5'd0;
            mask_reg      <= 7'd0;
            idx_reg       <= grg_pkg::IDX_BLANK;
            origin_x_reg  <= 16'd0;
            pen_x_reg     <= 16'd0;
            pen_y_reg     <= 16'd0;
            scale_reg     <= 4'd1;
            color_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= 16'd0;
            out_y_reg     <= 16'd0;
            out_w_reg     <= 7'd0;
            out_h_reg     <= 4'd0;
            out_color_reg <= 32'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        origin_x_reg <= eff_origin_x;
                        scale_reg    <= eff_scale;
                        color_reg    <= eff_color;
                        if (in_char == grg_pkg::CHAR_NEWLINE)
                        begin
                            pen_x_reg <= eff_origin_x;
                            pen_y_reg <= eff_pen_y + 16'(newline_step);
                        end
                        else
                        begin
                            pen_x_reg <= eff_pen_x;
                            pen_y_reg <= eff_pen_y;
                            idx_reg   <= in_idx;
                            mask_reg  <= row_mask(in_idx);
                            row_reg   <= 3'd0;
                            state_reg <= S_FETCH;
                        end
                    end
                end

                S_FETCH:
                begin
                    // A zero scale draws nothing, so the row is taken as empty.
                    rem_reg   <= (scale_reg == 4'd0) ? 5'd0 : rom_data;
                    state_reg <= S_RUN;
                end

                S_RUN:
                begin
                    if (rem_reg == 5'd0)
                    begin
                        if (row_reg == 3'd6)
                        begin
                            pen_x_reg <= pen_x_reg + 16'(advance);
                            row_reg   <= 3'd0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 3'd1;
                            state_reg <= S_FETCH;
                        end
                    end
                    else if (out_free)
                    begin
                        out_x_reg     <= pen_x_reg + 16'(x_off);
                        out_y_reg     <= pen_y_reg + 16'(y_off);
                        out_w_reg     <= w_val;
                        out_h_reg     <= scale_reg;
                        out_color_reg <= color_reg;
                        out_last_reg  <= (run.rest == 5'd0) && !later_rows;
                        rem_reg       <= run.rest;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'd0, out_color_reg, out_h_reg, out_w_reg, out_y_reg, out_x_reg};

    // The row counter never leaves the seven glyph rows.
    assert property (@(posedge clk) disable iff (!rst_n) row_reg <= 3'd6)
        else $error("row counter out of range");

    // Every emitted rectangle has a nonzero size.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[38:32] != 7'd0) && (m_axis_tdata[42:39] != 4'd0))
        else $error("empty rectangle emitted");

    // A row load always follows a ROM read issued in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> $past(rom_req.rd_en))
        else $error("row fetched without a ROM read");

    // The remaining bits of a row hold while the output register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && rem_reg != 5'd0 && !out_free) |=> $stable(rem_reg))
        else $error("row bits changed while output stalled");

endmodule
